// ===== src/hhcp_pkg.sv =====
// ----------------------------------------------------------------------------
// hhcp_pkg
// Shared types and constants of the HTTP header capture parser.
// ----------------------------------------------------------------------------
package hhcp_pkg;

   localparam int CHUNK_BYTES_DEF     = 32;
   localparam int MAX_CHUNKS_DEF      = 10;
   localparam int IP_HEADER_BYTES_DEF = 20;

   localparam logic [15:0] WATCHED_PORT_RESET = 16'd80;

   // TCP data offset byte, relative to the end of the IP header
   localparam int          TCP_DOFF_OFFSET = 12;
   localparam logic [3:0]  DOFF_MIN_WORDS  = 4'd4;
   localparam logic [31:0] HDR_TERMINATOR  = 32'h0D0A_0D0A;

   localparam logic [31:0] METHOD_HTTP = 32'h4854_5450;
   localparam logic [31:0] METHOD_POST = 32'h504F_5354;
   localparam logic [31:0] METHOD_HEAD = 32'h4845_4144;
   localparam logic [23:0] METHOD_GET  = 24'h47_4554;

   // results one word can cause at most
   localparam int RSP_SLOTS  = 3;
   localparam int FIFO_DEPTH = 4;

   // register index within the CSR space
   localparam logic CSR_WATCHED_PORT = 1'b0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_start;
      logic       chunk_last;
      logic       message_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                   count;
      rsp_type [RSP_SLOTS-1:0]      item;
   } push_type;

   function automatic logic method_ok(input logic [31:0] p);
      method_ok = (p == METHOD_HTTP) || (p == METHOD_POST) || (p == METHOD_HEAD) ||
                  (p[31:8] == METHOD_GET);
   endfunction

endpackage

// ===== src/hhcp_parse.sv =====
// ----------------------------------------------------------------------------
// hhcp_parse
// Input word register and per-byte parser: header walk, port and method check,
// chunking and terminator search. Emits up to three results per word.
// ----------------------------------------------------------------------------
module hhcp_parse #(
   parameter int CHUNK_BYTES     = hhcp_pkg::CHUNK_BYTES_DEF,
   parameter int MAX_CHUNKS      = hhcp_pkg::MAX_CHUNKS_DEF,
   parameter int IP_HEADER_BYTES = hhcp_pkg::IP_HEADER_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_pkt_byte,
   input  logic               req_first_byte,
   input  logic               req_last_byte,
   input  logic [15:0]        req_peer_port,
   input  logic [15:0]        watched_port,
   input  logic               space_ok,
   output logic               push_en,
   output hhcp_pkg::push_type push
);

   localparam int TOTAL = CHUNK_BYTES * MAX_CHUNKS;
   localparam int PCW   = $clog2(TOTAL + 1);
   localparam int CPW   = $clog2(CHUNK_BYTES);
   localparam logic [10:0]    DOFF_POS  = 11'(IP_HEADER_BYTES + hhcp_pkg::TCP_DOFF_OFFSET);
   localparam logic [6:0]     IP_LEN    = 7'(IP_HEADER_BYTES);
   localparam logic [PCW-1:0] LAST_K    = PCW'(TOTAL - 1);
   localparam logic [PCW-1:0] PREFIX_K  = PCW'(3);
   localparam logic [CPW-1:0] CHUNK_END = CPW'(CHUNK_BYTES - 1);

   // input word register
   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;
   logic        in_first_ff;
   logic        in_last_ff;
   logic [15:0] in_rport_ff;
   logic        go;

   // parser state
   logic [10:0]    pos_ff,   pos_in;
   logic [6:0]     pb_ff,    pb_in;
   logic           pm_ff,    pm_in;
   logic [23:0]    mp_ff,    mp_in;
   logic           cap_ff,   cap_in;
   logic [PCW-1:0] pc_ff,    pc_in;
   logic [CPW-1:0] cp_ff,    cp_in;
   logic [23:0]    tw_ff,    tw_in;
   logic [7:0]     hb_ff,    hb_in;
   logic           hv_ff,    hv_in;
   logic           inpkt_ff, inpkt_in;
   logic           owed_ff,  owed_in;

   assign go        = in_vld_ff && space_ok;
   assign req_ready = !in_vld_ff || go;
   assign push_en   = go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_pkt_byte;
         in_first_ff <= req_first_byte;
         in_last_ff  <= req_last_byte;
         in_rport_ff <= req_peer_port;
      end
   end

   always_comb begin
      logic [1:0]     n;
      logic [PCW-1:0] k;
      logic [31:0]    win;
      logic [31:0]    prefix;
      logic           fin;
      logic [6:0]     pbeg;
      n        = 2'd0;
      k        = pc_ff;
      win      = 32'd0;
      prefix   = 32'd0;
      fin      = 1'b0;
      pbeg     = 7'd0;
      push     = '0;
      pos_in   = pos_ff;
      pb_in    = pb_ff;
      pm_in    = pm_ff;
      mp_in    = mp_ff;
      cap_in   = cap_ff;
      pc_in    = pc_ff;
      cp_in    = cp_ff;
      tw_in    = tw_ff;
      hb_in    = hb_ff;
      hv_in    = hv_ff;
      owed_in  = owed_ff;

      // flush a fourth byte left over from a four-byte message
      if (owed_ff) begin
         push.item[n] = '{hb_ff, 1'b0, 1'b1, 1'b1};
         n            = n + 2'd1;
         owed_in      = 1'b0;
         hv_in        = 1'b0;
      end

      if (in_first_ff || !inpkt_ff) begin
         if (cap_ff && hv_in) begin
            push.item[n] = '{hb_ff, 1'b0, 1'b1, 1'b1};
            n            = n + 2'd1;
         end
         pos_in = 11'd0;
         pm_in  = (in_rport_ff == watched_port);
         pb_in  = 7'd0;
         cap_in = 1'b0;
         pc_in  = '0;
         cp_in  = '0;
         tw_in  = 24'd0;
         mp_in  = 24'd0;
         hv_in  = 1'b0;
      end else if (pos_ff != 11'h7FF) begin
         pos_in = pos_ff + 11'd1;
      end
      inpkt_in = !in_last_ff;

      if (pm_in) begin
         if (pos_in == DOFF_POS && pb_in == 7'd0) begin
            pbeg = IP_LEN + {1'b0, in_byte_ff[7:4], 2'b00};
            if (in_byte_ff[7:4] < hhcp_pkg::DOFF_MIN_WORDS) begin
               pm_in = 1'b0;
            end else begin
               pb_in = pbeg;
            end
         end else if (pb_in != 7'd0 && pos_in >= {4'd0, pb_in}) begin
            k      = pc_in;
            win    = {tw_in, in_byte_ff};
            fin    = in_last_ff || (k >= LAST_K);
            tw_in  = win[23:0];
            pc_in  = k + PCW'(1);
            cp_in  = (cp_ff == CHUNK_END) ? '0 : cp_ff + CPW'(1);
            if (!cap_in) begin
               prefix = {mp_in, in_byte_ff};
               mp_in  = prefix[23:0];
               if (k >= PREFIX_K) begin
                  if (!hhcp_pkg::method_ok(prefix)) begin
                     pm_in = 1'b0;
                  end else begin
                     cap_in = 1'b1;
                     push.item[n] = '{prefix[31:24], 1'b1, 1'b0, 1'b0};
                     n            = n + 2'd1;
                     push.item[n] = '{prefix[23:16], 1'b0, 1'b0, 1'b0};
                     n            = n + 2'd1;
                     push.item[n] = '{prefix[15:8], 1'b0, 1'b0, 1'b0};
                     n            = n + 2'd1;
                     hb_in        = in_byte_ff;
                     if (fin) begin
                        cap_in  = 1'b0;
                        pm_in   = 1'b0;
                        hv_in   = 1'b0;
                        owed_in = 1'b1;
                     end else begin
                        hv_in = 1'b1;
                     end
                  end
               end
            end else if (win == hhcp_pkg::HDR_TERMINATOR) begin
               // zero the second CR when it shares the chunk with the final LF
               if (hv_in) begin
                  push.item[n] = '{(cp_ff != '0) ? 8'd0 : hb_in, 1'b0,
                                   (cp_ff == '0), 1'b0};
                  n            = n + 2'd1;
               end
               push.item[n] = '{in_byte_ff, 1'b0, 1'b1, 1'b1};
               n            = n + 2'd1;
               cap_in       = 1'b0;
               pm_in        = 1'b0;
               hv_in        = 1'b0;
            end else begin
               if (hv_in) begin
                  push.item[n] = '{hb_in, 1'b0, (cp_ff == '0), 1'b0};
                  n            = n + 2'd1;
               end
               if (fin) begin
                  push.item[n] = '{in_byte_ff, 1'b0, 1'b1, 1'b1};
                  n            = n + 2'd1;
                  cap_in       = 1'b0;
                  pm_in        = 1'b0;
                  hv_in        = 1'b0;
               end else begin
                  hb_in = in_byte_ff;
                  hv_in = 1'b1;
               end
            end
         end
      end
      push.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 11'd0;
         pb_ff    <= 7'd0;
         pm_ff    <= 1'b0;
         mp_ff    <= 24'd0;
         cap_ff   <= 1'b0;
         pc_ff    <= '0;
         cp_ff    <= '0;
         tw_ff    <= 24'd0;
         hb_ff    <= 8'd0;
         hv_ff    <= 1'b0;
         inpkt_ff <= 1'b0;
         owed_ff  <= 1'b0;
      end else if (go) begin
         pos_ff   <= pos_in;
         pb_ff    <= pb_in;
         pm_ff    <= pm_in;
         mp_ff    <= mp_in;
         cap_ff   <= cap_in;
         pc_ff    <= pc_in;
         cp_ff    <= cp_in;
         tw_ff    <= tw_in;
         hb_ff    <= hb_in;
         hv_ff    <= hv_in;
         inpkt_ff <= inpkt_in;
         owed_ff  <= owed_in;
      end
   end

endmodule

// ===== src/hhcp_fifo.sv =====
// ----------------------------------------------------------------------------
// hhcp_fifo
// Result queue: takes up to three results per cycle, hands out one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module hhcp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_en,
   input  hhcp_pkg::push_type push,
   output logic               space_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hhcp_pkg::rsp_type  rsp_item
);

   localparam int DEPTH = hhcp_pkg::FIFO_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   hhcp_pkg::rsp_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_push;
   logic          pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign space_ok  = (count_ff <= CW'(DEPTH - hhcp_pkg::RSP_SLOTS));
   assign n_push    = push_en ? CW'(push.count) : '0;
   assign count_in  = count_ff + n_push - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + AW'(n_push);
         rd_ptr_ff <= rd_ptr_ff + AW'(pop);
         count_ff  <= count_in;
      end
      for (int i = 0; i < hhcp_pkg::RSP_SLOTS; i++) begin
         if (CW'(i) < n_push) begin
            entry_ff[wr_ptr_ff + AW'(i)] <= push.item[i];
         end
      end
   end

endmodule

// ===== src/http_header_capture_parser.sv =====
// ----------------------------------------------------------------------------
// http_header_capture_parser
// Walks IP/TCP headers byte by byte, checks the remote port and HTTP method,
// and forwards the request/response header in chunks up to CR LF CR LF.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | pkt_byte, first_byte, last_byte,
//           |           |                     | peer_port
//   rsp_    | out       | rsp_valid/rsp_ready | data_byte, message_start,
//           |           |                     | chunk_last, message_last
//   csr_    | in        | APB write/read      | watched_port at byte address 0
//
// One word per cycle is taken while the queue has room: a word is registered,
// then parsed, and its results (up to three) land in a four-entry result queue.
// A word waits in the input register while the queue has fewer than three free
// slots; results leave one per cycle while rsp_ready is high. Synchronous reset
// clears all parser state and sets watched_port to 80; no clearing pass is needed.
// ----------------------------------------------------------------------------
module http_header_capture_parser #(
   parameter int CHUNK_BYTES     = hhcp_pkg::CHUNK_BYTES_DEF,
   parameter int MAX_CHUNKS      = hhcp_pkg::MAX_CHUNKS_DEF,
   parameter int IP_HEADER_BYTES = hhcp_pkg::IP_HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pkt_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_peer_port,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_message_start,
   output logic        rsp_chunk_last,
   output logic        rsp_message_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0]        watched_port_ff;
   logic               csr_wr;
   logic               space_ok;
   logic               push_en;
   hhcp_pkg::push_type push;
   hhcp_pkg::rsp_type  rsp_item;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         watched_port_ff <= hhcp_pkg::WATCHED_PORT_RESET;
      end else if (csr_wr && csr_paddr[2] == hhcp_pkg::CSR_WATCHED_PORT) begin
         watched_port_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      case (csr_paddr[2])
         hhcp_pkg::CSR_WATCHED_PORT: csr_prdata = {16'd0, watched_port_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   hhcp_parse #(
      .CHUNK_BYTES    (CHUNK_BYTES),
      .MAX_CHUNKS     (MAX_CHUNKS),
      .IP_HEADER_BYTES(IP_HEADER_BYTES)
   ) u_parse (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pkt_byte   (req_pkt_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .req_peer_port  (req_peer_port),
      .watched_port   (watched_port_ff),
      .space_ok       (space_ok),
      .push_en        (push_en),
      .push           (push)
   );

   hhcp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_en  (push_en),
      .push     (push),
      .space_ok (space_ok),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   assign rsp_data_byte     = rsp_item.data_byte;
   assign rsp_message_start = rsp_item.message_start;
   assign rsp_chunk_last    = rsp_item.chunk_last;
   assign rsp_message_last  = rsp_item.message_last;

endmodule
